// ===== hw/rtl/mahd_pkg.sv =====
// Shared types, constants and lookup tables for the MPEG audio header decoder.
package mahd_pkg;

    // Sync byte that opens every header
    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // Raw version codes
    localparam logic [1:0] VER_25       = 2'd0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_2        = 2'd2;
    localparam logic [1:0] VER_1        = 2'd3;

    // Raw layer codes
    localparam logic [1:0] LAYER_RESERVED = 2'd0;
    localparam logic [1:0] LAYER_III      = 2'd1;
    localparam logic [1:0] LAYER_II       = 2'd2;
    localparam logic [1:0] LAYER_I        = 2'd3;

    localparam logic [3:0] BRI_BAD = 4'd15;
    localparam logic [1:0] SRI_BAD = 2'd3;

    // Samples per slot times 1000 (12 for layer I, 36 otherwise)
    localparam logic [15:0] SCALE_L1    = 16'd12000;
    localparam logic [15:0] SCALE_OTHER = 16'd36000;

    // Quotient width and divider steps (two quotient bits per cycle)
    localparam int QUO_W      = 10;
    localparam int DIV_CYCLES = QUO_W / 2;

    // Width of one queued header word (the three bytes after the sync byte)
    localparam int HDR_W = 24;

    // Queue status toward the front end and the back end
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Decoded result, header_ok in the lowest bit
    typedef struct packed {
        logic [11:0] frame_bytes;
        logic [9:0]  frame_slots;
        logic [1:0]  emphasis;
        logic [4:0]  flag_bits;
        logic [1:0]  mode_extension;
        logic [1:0]  channel_mode;
        logic [15:0] sample_rate_hz;
        logic [8:0]  bitrate_kbps;
        logic [1:0]  layer;
        logic [1:0]  version;
        logic        header_ok;
    } result_t;

    localparam logic [8:0] KBPS_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] KBPS_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] KBPS_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] KBPS_V2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam logic [8:0] KBPS_V2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};

    // Bitrate lookup; MPEG 2 and 2.5 share the lower rows
    function automatic logic [8:0] kbps_lookup(input logic [1:0] ver,
                                               input logic [1:0] lay,
                                               input logic [3:0] bri);
        logic [8:0] kbps;
        kbps = 9'd0;
        if (ver == VER_1)
        begin
            case (lay)
                LAYER_III: kbps = KBPS_V1_L3[bri];
                LAYER_II:  kbps = KBPS_V1_L2[bri];
                LAYER_I:   kbps = KBPS_V1_L1[bri];
                default:   kbps = 9'd0;
            endcase
        end
        else
        begin
            case (lay)
                LAYER_III, LAYER_II: kbps = KBPS_V2_L23[bri];
                LAYER_I:             kbps = KBPS_V2_L1[bri];
                default:             kbps = 9'd0;
            endcase
        end
        return kbps;
    endfunction

    // Sample rate lookup in hertz
    function automatic logic [15:0] hz_lookup(input logic [1:0] ver,
                                              input logic [1:0] sri);
        logic [15:0] base;
        logic [15:0] hz;
        base = 16'd0;
        hz   = 16'd0;
        case (sri)
            2'd0:    base = 16'd44100;
            2'd1:    base = 16'd48000;
            2'd2:    base = 16'd32000;
            default: base = 16'd0;
        endcase
        case (ver)
            VER_1:   hz = base;
            VER_2:   hz = base >> 1;
            VER_25:  hz = base >> 2;
            default: hz = 16'd0;
        endcase
        return hz;
    endfunction

endpackage

// ===== hw/rtl/mahd_front.sv =====
// Front end: hunts for the sync byte and gathers the three header bytes after it.
module mahd_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  mahd_pkg::q_status_t         q_stat,
    output logic                        q_push,
    output logic [mahd_pkg::HDR_W-1:0]  q_wdata
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_B1   = 2'd1;
    localparam logic [1:0] PH_B2   = 2'd2;
    localparam logic [1:0] PH_B3   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] buf_reg, buf_next;
    logic        accept;

    // Stall only on the last header byte when the queue is full
    assign s_tready = (phase_reg != PH_B3) || !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && (phase_reg == PH_B3);
    assign q_wdata  = {buf_reg, s_tdata};

    // Advance the byte phase; drop bytes while hunting
    always_comb
    begin
        phase_next = phase_reg;
        buf_next   = buf_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    phase_next = (s_tdata == mahd_pkg::SYNC_BYTE) ? PH_B1 : PH_HUNT;
                end
                PH_B1, PH_B2:
                begin
                    buf_next   = {buf_reg[7:0], s_tdata};
                    phase_next = phase_reg + 2'd1;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== hw/rtl/mahd_fifo.sv =====
// Small header queue between the front end and the back end.
module mahd_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [mahd_pkg::HDR_W-1:0]  wdata,
    input  logic                        pop,
    output logic [mahd_pkg::HDR_W-1:0]  rdata,
    output mahd_pkg::q_status_t         stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [mahd_pkg::HDR_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       do_push, do_pop;

    assign stat.full  = (cnt_reg == FULL_CNT);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/mahd_back.sv =====
// Back end: decodes a queued header, divides out the frame length, holds the result.
module mahd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  logic [mahd_pkg::HDR_W-1:0]  q_rdata,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output mahd_pkg::result_t           m_result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    localparam int QW    = mahd_pkg::QUO_W;
    localparam int DSH_W = 16 + QW - 1;
    localparam int CNT_W = $clog2(mahd_pkg::DIV_CYCLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mahd_pkg::DIV_CYCLES - 1);

    logic [1:0]                 state_reg, state_next;
    logic [mahd_pkg::HDR_W-1:0] hdr_reg;
    logic                       ok_reg;
    logic [8:0]                 kbps_reg;
    logic [15:0]                hz_reg;
    logic [23:0]                rem_reg;
    logic [DSH_W-1:0]           dsh_reg;
    logic [QW-1:0]              quo_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       out_valid_reg;
    mahd_pkg::result_t          out_reg;

    logic [1:0]  ver, lay, sri;
    logic [3:0]  bri;
    logic        ok_dec;
    logic [8:0]  kbps_dec;
    logic [15:0] hz_dec;
    logic [15:0] scale;
    logic [24:0] prod;
    logic [DSH_W:0] r0, r1, r2;
    logic [DSH_W-1:0] d1;
    logic        b1, b2;
    logic [QW-1:0] slots;
    logic        out_free;

    assign ver = hdr_reg[20:19];
    assign lay = hdr_reg[18:17];
    assign bri = hdr_reg[15:12];
    assign sri = hdr_reg[11:10];

    // Check sync and reserved codes, then look up rates
    always_comb
    begin
        ok_dec = (hdr_reg[23:21] == 3'b111)
                 && (ver != mahd_pkg::VER_RESERVED)
                 && (lay != mahd_pkg::LAYER_RESERVED)
                 && (bri != mahd_pkg::BRI_BAD)
                 && (sri != mahd_pkg::SRI_BAD);
        kbps_dec = ok_dec ? mahd_pkg::kbps_lookup(ver, lay, bri) : 9'd0;
        hz_dec   = ok_dec ? mahd_pkg::hz_lookup(ver, sri) : 16'd0;
        scale    = (lay == mahd_pkg::LAYER_I) ? mahd_pkg::SCALE_L1
                                              : mahd_pkg::SCALE_OTHER;
        prod     = 25'(kbps_dec) * 25'(scale);
    end

    // Two restoring division steps per cycle
    always_comb
    begin
        r0 = (DSH_W + 1)'(rem_reg);
        b1 = (r0 >= {1'b0, dsh_reg});
        r1 = b1 ? (r0 - {1'b0, dsh_reg}) : r0;
        d1 = dsh_reg >> 1;
        b2 = (r1 >= {1'b0, d1});
        r2 = b2 ? (r1 - {1'b0, d1}) : r1;
    end

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign slots    = quo_reg + QW'(hdr_reg[9]);

    // Sequence one header through decode, divide and hand-off
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   state_next = q_valid ? S_DECODE : S_IDLE;
            S_DECODE: state_next = S_DIV;
            S_DIV:    state_next = (cnt_reg == CNT_LAST) ? S_DONE : S_DIV;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DECODE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    hdr_reg <= q_rdata;
                end
            end
            S_DECODE:
            begin
                ok_reg   <= ok_dec;
                kbps_reg <= kbps_dec;
                hz_reg   <= hz_dec;
                rem_reg  <= prod[23:0];
                dsh_reg  <= {hz_dec, (QW - 1)'(0)};
                quo_reg  <= '0;
            end
            S_DIV:
            begin
                rem_reg <= r2[23:0];
                dsh_reg <= d1 >> 1;
                quo_reg <= {quo_reg[QW-3:0], b1, b2};
            end
            default:
            begin
                if (out_free)
                begin
                    out_reg.header_ok      <= ok_reg;
                    out_reg.version        <= ver;
                    out_reg.layer          <= lay;
                    out_reg.bitrate_kbps   <= kbps_reg;
                    out_reg.sample_rate_hz <= hz_reg;
                    out_reg.channel_mode   <= hdr_reg[7:6];
                    out_reg.mode_extension <= hdr_reg[5:4];
                    out_reg.flag_bits      <= {hdr_reg[2], hdr_reg[3], hdr_reg[8],
                                               hdr_reg[9], hdr_reg[16]};
                    out_reg.emphasis       <= hdr_reg[1:0];
                    out_reg.frame_slots    <= ok_reg ? slots : '0;
                    out_reg.frame_bytes    <= ok_reg ? {slots, 2'b00} : 12'd0;
                end
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ===== hw/rtl/mpeg_audio_header_decoder.sv =====
// Top level of the MPEG audio frame header decoder.
//
// Usage:
//   s_* carries the raw audio stream, one byte per word. Bytes are dropped
//   until 0xFF; that byte and the next three form one 32-bit header.
//   m_* carries one decoded header word per header, whether or not it is
//   valid (header_ok tells). Rate and length fields read zero when not ok.
// Sequence: after the fourth header byte is taken and queued, the back end
//   reads the queue, does the table lookup and multiply, runs the
//   two-bit-per-cycle divider, then loads the output register.
// Pacing: the back end takes no new header from the queue until it has
//   handed off the last one's result; bytes outside a header are taken
//   every cycle.
// Stall: a header queue of FIFO_DEPTH entries sits between the byte front
//   end and the decode back end; the input stalls only on a header's last
//   byte when that queue is full. The output holds its word until taken.
// Reset: rst_n clears the byte phase to hunting, empties the queue and
//   drops any pending result.
module mpeg_audio_header_decoder
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] header_ok, [2:1] version, [4:3] layer, [13:5] bitrate_kbps,
    // [29:14] sample_rate_hz, [31:30] channel_mode, [33:32] mode_extension,
    // [38:34] flag_bits, [40:39] emphasis, [50:41] frame_slots,
    // [62:51] frame_bytes, [63] zero
    output logic [63:0] m_tdata
);

    mahd_pkg::q_status_t        q_stat;
    logic                       q_push, q_pop;
    logic [mahd_pkg::HDR_W-1:0] q_wdata, q_rdata;
    mahd_pkg::result_t          result;

    mahd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    mahd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    mahd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (!q_stat.empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {1'b0, result};

`ifndef ASSERT_OFF
    // Never push a header into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("header pushed into full queue");

    // A rejected header carries no rates or lengths
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !result.header_ok) |->
            (result.frame_slots == '0 && result.frame_bytes == '0
             && result.bitrate_kbps == '0 && result.sample_rate_hz == '0))
        else $error("rejected header carries nonzero fields");

    // Frame bytes are four times frame slots
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.frame_bytes == {result.frame_slots, 2'b00}))
        else $error("frame_bytes does not match frame_slots");
`endif

endmodule
